[design/i4q_pkg.sv]
`timescale 1ns / 1ps
// Shared types and helpers for the int4 pair quantizer.
// No dependencies.
package i4q_pkg;

    localparam int ManW = 24;
    localparam int ExpW = 10;
    localparam int ProdW = 2 * ManW;
    localparam int XW = 11;
    localparam logic [2:0] QMax = 3'd7;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_SAT,
        KIND_NUM
    } kind_t;

    typedef struct packed {
        logic                   sign;
        logic                   nan;
        logic                   inf;
        logic                   zero;
        logic signed [ExpW-1:0] exp;
        logic [ManW-1:0]        man;
    } op_t;

    function automatic kind_t kind_of(op_t a, op_t b);
        kind_t k;
        k = KIND_NUM;
        if (a.nan || b.nan)
        begin
            k = KIND_ZERO;
        end
        else if (a.inf || b.inf)
        begin
            k = (a.zero || b.zero) ? KIND_ZERO : KIND_SAT;
        end
        else if (a.zero || b.zero)
        begin
            k = KIND_ZERO;
        end
        return k;
    endfunction

endpackage

[design/i4q_norm.sv]
`timescale 1ns / 1ps
// Classifies one fp32 operand and normalises its significand to bit 23.
// Depends on i4q_pkg.
module i4q_norm (
    input  logic [31:0]   value,
    output i4q_pkg::op_t  op
);

    logic [7:0]  e;
    logic [22:0] f;
    logic [4:0]  pos;
    logic [4:0]  shift;

    always_comb
    begin
        e = value[30:23];
        f = value[22:0];
        pos = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (f[i])
            begin
                pos = 5'(i);
            end
        end
        shift = 5'd23 - pos;
        op.sign = value[31];
        op.nan  = (e == 8'hFF) && (f != 23'd0);
        op.inf  = (e == 8'hFF) && (f == 23'd0);
        op.zero = (e == 8'd0) && (f == 23'd0);
        if (e == 8'd0)
        begin
            op.man = {1'b0, f} << shift;
            op.exp = 10'sd1 - $signed({5'd0, shift});
        end
        else
        begin
            op.man = {1'b1, f};
            op.exp = $signed({2'd0, e});
        end
    end

endmodule

[design/i4q_round.sv]
`timescale 1ns / 1ps
// Rounds a 48-bit product to fp32, then to an int4 nibble clamped to -7..7.
// Depends on i4q_pkg.
module i4q_round (
    input  i4q_pkg::kind_t                  kind,
    input  logic                            neg,
    input  logic [i4q_pkg::ProdW-1:0]       prod,
    input  logic signed [i4q_pkg::XW-1:0]   x,
    output logic [3:0]                      nibble
);

    logic [i4q_pkg::ProdW-1:0] pn;
    logic signed [11:0]        t;
    logic [23:0]               rem;
    logic [24:0]               keep;
    logic [4:0]                sh;
    logic [25:0]               sum;
    logic [25:0]               qw;
    logic [2:0]                mag;

    always_comb
    begin
        if (prod[i4q_pkg::ProdW-1])
        begin
            pn = prod;
            t  = 12'sd47 + 12'(x);
        end
        else
        begin
            pn = prod << 1;
            t  = 12'sd46 + 12'(x);
        end
        rem  = pn[23:0];
        keep = {1'b0, pn[47:24]};
        if (rem > 24'h800000 || (rem == 24'h800000 && pn[24]))
        begin
            keep = keep + 25'd1;
        end
        case (t)
            -12'sd2: sh = 5'd25;
            -12'sd1: sh = 5'd24;
            12'sd0:  sh = 5'd23;
            12'sd1:  sh = 5'd22;
            default: sh = 5'd21;
        endcase
        sum = {1'b0, keep} + (26'd1 << (sh - 5'd1));
        qw  = sum >> sh;
        if (kind == i4q_pkg::KIND_ZERO)
        begin
            mag = 3'd0;
        end
        else if (kind == i4q_pkg::KIND_SAT || t >= 12'sd3)
        begin
            mag = i4q_pkg::QMax;
        end
        else if (t <= -12'sd3)
        begin
            mag = 3'd0;
        end
        else if (qw > 26'd7)
        begin
            mag = i4q_pkg::QMax;
        end
        else
        begin
            mag = qw[2:0];
        end
        nibble = neg ? (4'd0 - {1'b0, mag}) : {1'b0, mag};
    end

endmodule

[design/fp32_to_int4_pair_quantize_pack.sv]
`timescale 1ns / 1ps
// Quantises a pair of fp32 values by the inverse scale register into two
// int4 nibbles packed in one byte. Depends on i4q_pkg, i4q_norm, i4q_round.
// Throughput is one pair per cycle; from acceptance a pair passes to the
// result register through the stages input, normalise, 24x24 multiply and
// round. The whole pipeline stalls together while a result waits to be
// taken.
module fp32_to_int4_pair_quantize_pack (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] first_value,
    input  logic [31:0] second_value,
    input  logic        last_pair,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  packed_byte,
    output logic        last_out
);

    logic        advance;
    logic [31:0] scale_reg;
    logic [3:0]  vld_reg;
    logic [3:0]  last_reg;
    logic [31:0] val_reg [2];
    i4q_pkg::op_t scale_op;
    i4q_pkg::op_t val_op [2];

    i4q_pkg::kind_t                    kind1_reg [2];
    logic                              neg1_reg  [2];
    logic [i4q_pkg::ManW-1:0]          ma1_reg   [2];
    logic [i4q_pkg::ManW-1:0]          mb1_reg   [2];
    logic signed [i4q_pkg::ExpW-1:0]   ea1_reg   [2];
    logic signed [i4q_pkg::ExpW-1:0]   eb1_reg   [2];

    i4q_pkg::kind_t                    kind2_reg [2];
    logic                              neg2_reg  [2];
    logic [i4q_pkg::ProdW-1:0]         prod2_reg [2];
    logic signed [i4q_pkg::XW-1:0]     x2_reg    [2];

    logic [3:0]  nib [2];
    logic [7:0]  byte_reg;

    assign advance   = !vld_reg[3] || out_ready;
    assign in_ready  = advance;
    assign out_valid = vld_reg[3];
    assign packed_byte = byte_reg;
    assign last_out  = last_reg[3];

    i4q_norm u_norm_s (.value(scale_reg), .op(scale_op));

    for (genvar g = 0; g < 2; g++)
    begin : g_lane
        i4q_norm u_norm (.value(val_reg[g]), .op(val_op[g]));
        i4q_round u_round (
            .kind   (kind2_reg[g]),
            .neg    (neg2_reg[g]),
            .prod   (prod2_reg[g]),
            .x      (x2_reg[g]),
            .nibble (nib[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 32'd0;
            vld_reg   <= 4'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
            if (advance)
            begin
                vld_reg <= {vld_reg[2:0], in_valid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            val_reg[0] <= first_value;
            val_reg[1] <= second_value;
            last_reg   <= {last_reg[2:0], last_pair};
            for (int i = 0; i < 2; i++)
            begin
                kind1_reg[i] <= i4q_pkg::kind_of(val_op[i], scale_op);
                neg1_reg[i]  <= val_op[i].sign ^ scale_op.sign;
                ma1_reg[i]   <= val_op[i].man;
                mb1_reg[i]   <= scale_op.man;
                ea1_reg[i]   <= val_op[i].exp;
                eb1_reg[i]   <= scale_op.exp;
                kind2_reg[i] <= kind1_reg[i];
                neg2_reg[i]  <= neg1_reg[i];
                prod2_reg[i] <= ma1_reg[i] * mb1_reg[i];
                x2_reg[i]    <= 11'(ea1_reg[i]) + 11'(eb1_reg[i]) - 11'sd300;
            end
            byte_reg <= {nib[1], nib[0]};
        end
    end

endmodule

[design/i4q_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the int4 pair quantizer, bound to the top level.
// Depends on fp32_to_int4_pair_quantize_pack.
module i4q_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  packed_byte,
    input logic        last_out
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packed_byte) && $stable(last_out))
        else $error("result changed while stalled");

    a_no_min_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> packed_byte[3:0] != 4'h8 && packed_byte[7:4] != 4'h8)
        else $error("nibble outside -7..7");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input blocked with free output");

endmodule

bind fp32_to_int4_pair_quantize_pack i4q_checker u_i4q_checker (.*);
